// ----- rtl/ptpq_pkg.sv -----
// shared types, constants and codes for the packet timestamp priority queue
package ptpq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int STAMP_W  = 48;
  localparam int PORT_W   = 16;
  localparam int OCC_W    = 7;
  localparam int STATUS_W = 2;

  // key layout: microsecond bucket, then port, then sub-microsecond remainder
  localparam int BUCKET_W = 39;
  localparam int REM_W    = 10;

  // stamp / 1000 runs as four 12-bit digits, one per cycle
  localparam int DIGIT_W  = 12;
  localparam int DIGITS   = STAMP_W / DIGIT_W;
  localparam int DCNT_W   = $clog2(DIGITS);
  localparam int PART_W   = REM_W + DIGIT_W;
  localparam int NDIV_W   = PART_W - 3;
  localparam int RECIP_W  = 20;
  localparam int PROD_W   = NDIV_W + RECIP_W;
  // (r >> 3) / 125 as a multiply by ceil(2^26 / 125), exact for r < 2^22
  localparam logic [RECIP_W-1:0] RECIP = 20'd536871;
  localparam int RECIP_SHIFT = 26;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic               operation;
    logic [STAMP_W-1:0] stamp_ns;
    logic [PORT_W-1:0]  port_number;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [STAMP_W-1:0]  out_stamp_ns;
    logic [PORT_W-1:0]   out_port;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [PORT_W-1:0]   port;
    logic [REM_W-1:0]    rem;
  } key_t;

  typedef struct packed {
    logic valid;
    key_t key;
  } cell_state_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic push;
    logic pop;
    key_t key;
  } cell_cmd_t;

endpackage

// ----- rtl/packet_timestamp_priority_queue.sv -----
// top level of the packet timestamp priority queue
//
// Bounded min-priority queue of packet descriptors (48-bit ns stamp, 16-bit port).
// Input channel in_valid/in_stall/in_data carries one request: push or pop.
// Output channel out_valid/out_stall/out_data returns one result per request:
// status, popped descriptor (zero unless popped) and occupancy after the request.
// Ordering key: stamp / 1000, then port, then stamp % 1000; descriptors sit
// sorted in a chain of QUEUE_DEPTH cells, smallest at the head.
// A push runs the stamp through digit-serial division by 1000 and inserts the
// key into the chain; a pop reads the head and rebuilds its stamp; a push to a
// full queue or pop of an empty one goes straight to the result state.
// One request is in flight at a time; in_stall is high while it is worked on,
// so a new request is taken only after the last result moves to the output register.
// The output register holds a result while out_stall is high, and the next
// request is already accepted; its result waits until the register frees.
// Reset empties the queue at once (cell valid bits clear); no clearing pass.
module packet_timestamp_priority_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  ptpq_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ptpq_pkg::res_t out_data
);
  import ptpq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CONV   = 4'b0010,
    S_RECON  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count;
  logic [PORT_W-1:0]  port_q;
  key_t               pop_key;
  res_t               res;

  logic               in_accept;
  logic               out_free;
  logic               is_full;
  logic               is_empty;
  logic               conv_start;
  logic               conv_done;
  logic [BUCKET_W-1:0] conv_bucket;
  logic [REM_W-1:0]   conv_rem;
  logic [STAMP_W+1:0] stamp_wide;

  cell_cmd_t          cmd;
  cell_state_t        cells [QUEUE_DEPTH];
  logic               ins   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_vec;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign is_full   = (count == CNT_W'(QUEUE_DEPTH));
  assign is_empty  = (count == '0);
  assign conv_start = in_accept && (in_data.operation == OP_PUSH) && !is_full;

  ptpq_key_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (conv_start),
    .stamp  (in_data.stamp_ns),
    .done   (conv_done),
    .bucket (conv_bucket),
    .rem    (conv_rem)
  );

  always_comb begin
    cmd.push       = (state == S_CONV) && conv_done;
    cmd.pop        = in_accept && (in_data.operation == OP_POP) && !is_empty;
    cmd.key.bucket = conv_bucket;
    cmd.key.port   = port_q;
    cmd.key.rem    = conv_rem;
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_state_t left_s, right_s;
    logic        left_ins_s;
    if (i == 0) begin : g_head
      assign left_s     = '0;
      assign left_ins_s = 1'b0;
    end else begin : g_body
      assign left_s     = cells[i-1];
      assign left_ins_s = ins[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_s = '0;
    end else begin : g_inner
      assign right_s = cells[i+1];
    end
    ptpq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .left     (left_s),
      .left_ins (left_ins_s),
      .right    (right_s),
      .state    (cells[i]),
      .ins      (ins[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  // stamp = bucket * 1000 + rem, with 1000 = 1024 - 16 - 8
  assign stamp_wide = {1'b0, pop_key.bucket, 10'b0}
                    - (STAMP_W+2)'({pop_key.bucket, 4'b0})
                    - (STAMP_W+2)'({pop_key.bucket, 3'b0})
                    + (STAMP_W+2)'(pop_key.rem);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (in_data.operation == OP_PUSH) begin
            state_next = is_full ? S_RESULT : S_CONV;
          end else begin
            state_next = is_empty ? S_RESULT : S_RECON;
          end
        end
      end
      S_CONV:   if (conv_done) state_next = S_RESULT;
      S_RECON:  state_next = S_RESULT;
      S_RESULT: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        count <= count - 1'b1;
      end
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      port_q           <= in_data.port_number;
      pop_key          <= cells[0].key;
      res.out_stamp_ns <= '0;
      res.out_port     <= '0;
      res.occupancy    <= OCC_W'(count);
      if (in_data.operation == OP_PUSH) begin
        res.status <= is_full ? ST_FULL : ST_PUSHED;
      end else begin
        res.status <= is_empty ? ST_EMPTY : ST_POPPED;
      end
    end else if (cmd.push) begin
      res.occupancy <= OCC_W'(count + 1'b1);
    end else if (state == S_RECON) begin
      res.out_stamp_ns <= stamp_wide[STAMP_W-1:0];
      res.out_port     <= pop_key.port;
      res.occupancy    <= OCC_W'(count);
    end
    if (state == S_RESULT && out_free) begin
      out_data <= res;
    end
  end

  // the number of occupied cells always matches the occupancy count
  assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("cell valid bits disagree with occupancy count");

  // the head of the chain never holds a larger key than its neighbor
  assert property (@(posedge clk) disable iff (rst)
    cells[1].valid |-> !(cells[1].key < cells[0].key))
    else $error("head of queue is not the smallest key");

  // a pop of a non-empty queue removes exactly one descriptor
  assert property (@(posedge clk) disable iff (rst)
    cmd.pop |=> count == $past(count) - 1'b1)
    else $error("pop did not reduce occupancy by one");

  // a result only leaves the working states through the output register
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RESULT) && out_free |=> out_valid && (state == S_IDLE))
    else $error("finished request not handed to output register");

endmodule

// ----- rtl/ptpq_key_conv.sv -----
// splits a nanosecond stamp into microsecond bucket and remainder, one digit a cycle
module ptpq_key_conv (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ptpq_pkg::STAMP_W-1:0]  stamp,
  output logic                          done,
  output logic [ptpq_pkg::BUCKET_W-1:0] bucket,
  output logic [ptpq_pkg::REM_W-1:0]    rem
);
  import ptpq_pkg::*;

  logic                     busy;
  logic [DCNT_W-1:0]        cnt;
  logic [STAMP_W-1:0]       work;
  logic [DIGITS*DIGIT_W-1:0] quo;
  logic [REM_W-1:0]         part_rem;

  logic [PART_W-1:0]  part;
  logic [PROD_W-1:0]  prod;
  logic [DIGIT_W-1:0] qdig;
  logic [PART_W-1:0]  qmul;
  logic [PART_W-1:0]  rem_next;

  always_comb begin
    part     = {part_rem, work[STAMP_W-1 -: DIGIT_W]};
    prod     = PROD_W'(part[PART_W-1:3]) * PROD_W'(RECIP);
    qdig     = prod[RECIP_SHIFT +: DIGIT_W];
    // q * 1000 = q * 1024 - q * 16 - q * 8
    qmul     = {qdig, 10'b0} - PART_W'({qdig, 4'b0}) - PART_W'({qdig, 3'b0});
    rem_next = part - qmul;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work     <= stamp;
      quo      <= '0;
      part_rem <= '0;
    end else if (busy) begin
      work     <= {work[STAMP_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
      quo      <= {quo[DIGITS*DIGIT_W-DIGIT_W-1:0], qdig};
      part_rem <= rem_next[REM_W-1:0];
    end
  end

  assign bucket = quo[BUCKET_W-1:0];
  assign rem    = part_rem;

endmodule

// ----- rtl/ptpq_cell.sv -----
// one slot of the sorted chain: keeps a key, shifts right on insert, left on pop
module ptpq_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  ptpq_pkg::cell_cmd_t    cmd,
  input  ptpq_pkg::cell_state_t  left,
  input  logic                   left_ins,
  input  ptpq_pkg::cell_state_t  right,
  output ptpq_pkg::cell_state_t  state,
  output logic                   ins
);
  import ptpq_pkg::*;

  // the new key lands here or further left when this slot is empty or larger
  assign ins = !state.valid || (cmd.key < state.key);

  always_ff @(posedge clk) begin
    if (rst) begin
      state.valid <= 1'b0;
    end else begin
      // push and pop never come together; most cycles neither is set
      if (cmd.push && ins) begin
        if (left_ins) begin
          state <= left;
        end else begin
          state.valid <= 1'b1;
          state.key   <= cmd.key;
        end
      end else if (cmd.pop) begin
        state <= right;
      end
    end
  end

endmodule

// ----- dv/packet_timestamp_priority_queue_test.sv -----
// self-checking testbench for the packet timestamp priority queue
`timescale 1ns / 100ps

module packet_timestamp_priority_queue_test;
  import ptpq_pkg::*;

  localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};
  localparam logic [PORT_W-1:0]  PORT_MAX  = {PORT_W{1'b1}};
  localparam int DRAIN_CYCLES = 20;
  localparam int N_STEPS = 23;

  typedef struct packed {
    logic               operation;
    logic [STAMP_W-1:0] stamp_ns;
    logic [PORT_W-1:0]  port_number;
    logic               typed;
    res_t               res;
  } step_t;

  // typed rows hold the result by hand, the others take it from the shadow queue
  localparam step_t STEPS [0:N_STEPS-1] = '{
    '{OP_POP,  48'd0,     16'd0,    1'b1, '{ST_EMPTY,  48'd0,     16'd0,    7'd0}},
    '{OP_POP,  STAMP_MAX, PORT_MAX, 1'b1, '{ST_EMPTY,  48'd0,     16'd0,    7'd0}},
    '{OP_PUSH, STAMP_MAX, PORT_MAX, 1'b1, '{ST_PUSHED, 48'd0,     16'd0,    7'd1}},
    '{OP_PUSH, 48'd0,     16'd0,    1'b1, '{ST_PUSHED, 48'd0,     16'd0,    7'd2}},
    '{OP_POP,  48'd0,     16'd0,    1'b1, '{ST_POPPED, 48'd0,     16'd0,    7'd1}},
    '{OP_POP,  48'd0,     16'd0,    1'b1, '{ST_POPPED, STAMP_MAX, PORT_MAX, 7'd0}},
    '{OP_PUSH, 48'd1000,  16'd2,    1'b0, '0},
    '{OP_PUSH, 48'd1999,  16'd1,    1'b0, '0},
    '{OP_PUSH, 48'd999,   PORT_MAX, 1'b0, '0},
    '{OP_PUSH, 48'd1500,  16'd1,    1'b0, '0},
    '{OP_POP,  48'd0,     16'd0,    1'b0, '0},
    '{OP_POP,  48'd0,     16'd0,    1'b0, '0},
    '{OP_POP,  48'd0,     16'd0,    1'b0, '0},
    '{OP_POP,  48'd0,     16'd0,    1'b0, '0},
    '{OP_PUSH, 48'd5000,  16'd7,    1'b0, '0},
    '{OP_PUSH, 48'd5000,  16'd7,    1'b0, '0},
    '{OP_POP,  48'd0,     16'd0,    1'b0, '0},
    '{OP_POP,  48'd0,     16'd0,    1'b0, '0},
    '{OP_POP,  48'd0,     16'd0,    1'b1, '{ST_EMPTY,  48'd0,     16'd0,    7'd0}},
    '{OP_PUSH, 48'h8000_0000_0000, 16'h8000, 1'b0, '0},
    '{OP_PUSH, 48'h7FFF_FFFF_FFFF, 16'h7FFF, 1'b0, '0},
    '{OP_POP,  48'd0,     16'd0,    1'b0, '0},
    '{OP_POP,  48'd0,     16'd0,    1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  res_t out_data;

  packet_timestamp_priority_queue u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the stored descriptors
  logic [STAMP_W-1:0] shadow_stamp [QUEUE_DEPTH];
  logic [PORT_W-1:0]  shadow_port  [QUEUE_DEPTH];
  int                 shadow_count;

  res_t due_results [$];
  int   errors;
  int   requests_sent;
  int   n_pushed, n_popped, n_empty, n_full;

  int idle_pct;
  int stall_pct;
  int hold_req;
  int hold_left;

  logic [STAMP_W-1:0] cluster_base;
  logic [STAMP_W-1:0] recent_stamp;
  logic [PORT_W-1:0]  recent_port;

  // composite key order: microsecond bucket, port, sub-microsecond remainder
  function automatic logic desc_precedes(logic [STAMP_W-1:0] sa, logic [PORT_W-1:0] pa,
                                         logic [STAMP_W-1:0] sb, logic [PORT_W-1:0] pb);
    logic [STAMP_W-1:0] ba, bb;
    ba = sa / 48'd1000;
    bb = sb / 48'd1000;
    if (ba != bb) return ba < bb;
    if (pa != pb) return pa < pb;
    return (sa % 48'd1000) < (sb % 48'd1000);
  endfunction

  function automatic res_t apply_to_shadow(in_t req);
    res_t r;
    int   best;
    r = '0;
    if (req.operation == OP_PUSH) begin
      if (shadow_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        shadow_stamp[shadow_count] = req.stamp_ns;
        shadow_port[shadow_count]  = req.port_number;
        shadow_count++;
        r.status = ST_PUSHED;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (desc_precedes(shadow_stamp[i], shadow_port[i], shadow_stamp[best], shadow_port[best]))
          best = i;
      end
      r.out_stamp_ns = shadow_stamp[best];
      r.out_port     = shadow_port[best];
      shadow_stamp[best] = shadow_stamp[shadow_count-1];
      shadow_port[best]  = shadow_port[shadow_count-1];
      shadow_count--;
      r.status = ST_POPPED;
    end
    r.occupancy = OCC_W'(shadow_count);
    return r;
  endfunction

  // hold the request until accepted, then log what it must return
  task automatic offer(input in_t req, input logic typed, input res_t typed_res);
    res_t predicted;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predicted = apply_to_shadow(req);
    if (typed) predicted = typed_res;
    due_results = {due_results, predicted};
    requests_sent++;
  endtask

  task automatic offer_after_gap(input in_t req);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    offer(req, 1'b0, '0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic in_t rand_request(int push_pct);
    in_t req;
    int  pick;
    req.operation = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
    pick = $urandom_range(9);
    case (pick)
      0, 1, 2: req.stamp_ns = 48'({$urandom, $urandom});
      3, 4, 5: req.stamp_ns = cluster_base + 48'($urandom_range(2999));
      6: begin
        case ($urandom_range(3))
          0: req.stamp_ns = '0;
          1: req.stamp_ns = STAMP_MAX;
          2: req.stamp_ns = 48'd999;
          default: req.stamp_ns = STAMP_MAX - 48'($urandom_range(2000));
        endcase
      end
      7, 8: req.stamp_ns = recent_stamp;
      default: req.stamp_ns = 48'($urandom_range(9999));
    endcase
    if (pick == 7 || pick == 8)
      req.port_number = recent_port;
    else if ($urandom_range(1))
      req.port_number = 16'($urandom);
    else
      req.port_number = 16'($urandom_range(3));
    if (req.operation == OP_PUSH) begin
      recent_stamp = req.stamp_ns;
      recent_port  = req.port_number;
    end
    return req;
  endfunction

  // runs of pushes and pops with a drifting mix so the queue swings full and empty
  task automatic run_random(input int n, input int sender_idle, input int receiver_stall);
    int push_pct;
    int run_left;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    run_left  = 0;
    push_pct  = 50;
    for (int i = 0; i < n; i++) begin
      if (run_left == 0) begin
        case ($urandom_range(3))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 85;
          default: push_pct = 97;
        endcase
        run_left = $urandom_range(16, 80);
        cluster_base = 48'({$urandom, $urandom});
        if (cluster_base > STAMP_MAX - 48'd3000) cluster_base = STAMP_MAX - 48'd3000;
      end
      run_left--;
      offer_after_gap(rand_request(push_pct));
    end
  endtask

  // receiver: random stall, or a long hold-off counted here
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result with no request waiting: status %0d", out_data.status);
        errors++;
      end else begin
        want = due_results.pop_front();
        if (out_data.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          errors++;
        end
        if (out_data.out_stamp_ns != want.out_stamp_ns) begin
          $error("out_stamp_ns: expected %0h, got %0h", want.out_stamp_ns,
                 out_data.out_stamp_ns);
          errors++;
        end
        if (out_data.out_port != want.out_port) begin
          $error("out_port: expected %0h, got %0h", want.out_port, out_data.out_port);
          errors++;
        end
        if (out_data.occupancy != want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, out_data.occupancy);
          errors++;
        end
        case (out_data.status)
          ST_PUSHED: n_pushed++;
          ST_POPPED: n_popped++;
          ST_EMPTY:  n_empty++;
          default:   n_full++;
        endcase
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    in_t req;
    int  waited;
    errors = 0;
    requests_sent = 0;
    n_pushed = 0;
    n_popped = 0;
    n_empty = 0;
    n_full = 0;
    shadow_count = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    cluster_base = '0;
    recent_stamp = '0;
    recent_port = '0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows
    for (int i = 0; i < N_STEPS; i++) begin
      req.operation   = STEPS[i].operation;
      req.stamp_ns    = STEPS[i].stamp_ns;
      req.port_number = STEPS[i].port_number;
      offer(req, STEPS[i].typed, STEPS[i].res);
    end

    // fill to the brim, then one push that must be dropped
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      req.operation   = OP_PUSH;
      req.stamp_ns    = 48'({$urandom, $urandom});
      req.port_number = 16'($urandom);
      offer(req, 1'b0, '0);
    end
    req.stamp_ns = 48'd12345;
    offer(req, 1'b1, '{ST_FULL, 48'd0, 16'd0, OCC_W'(QUEUE_DEPTH)});
    wait_drained();

    run_random(250, 0, 0);

    // long receiver hold-off while requests keep coming
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 400;
    for (int i = 0; i < 20; i++) offer(rand_request(60), 1'b0, '0);
    wait_drained();

    run_random(230, 79, 0);
    wait_drained();
    run_random(230, 0, 79);
    run_random(230, 24, 24);

    in_valid <= 1'b0;
    waited = 0;
    while (due_results.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      errors++;
    end

    $display("%0d requests: %0d stored, %0d popped, %0d pops on empty, %0d drops on full",
             requests_sent, n_pushed, n_popped, n_empty, n_full);
    $display("idle mixes none/sender/receiver/both, one long output hold-off, %0d errors",
             errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- packet_timestamp_priority_queue.f -----
rtl/ptpq_pkg.sv
rtl/ptpq_key_conv.sv
rtl/ptpq_cell.sv
rtl/packet_timestamp_priority_queue.sv
dv/packet_timestamp_priority_queue_test.sv
